// File: src/aabbcr_pkg.sv
package aabbcr_pkg;

	localparam int unsigned PW = 41;      // scaled push magnitude
	localparam int unsigned QW = 41;      // quotient bits
	localparam int unsigned NW = 57;      // dividend: push times inverse mass
	localparam int unsigned DW = 17;      // divisor: sum of inverse masses
	localparam int unsigned GW = 36;      // doubled centre gaps, scale factor
	localparam logic [23:0] STEP_RECIP_RESET = 24'd3932160;
	localparam logic [0:0]  REG_STEP_RECIP = 1'b0;

	typedef struct packed {
		logic signed [31:0] cur_x_pos;
		logic signed [31:0] cur_y_pos;
		logic        [30:0] cur_width;
		logic        [30:0] cur_height;
		logic signed [31:0] oth_x_pos;
		logic signed [31:0] oth_y_pos;
		logic        [30:0] oth_width;
		logic        [30:0] oth_height;
		logic        [8:0]  cur_bounce;
		logic        [8:0]  oth_bounce;
		logic        [15:0] cur_inv_mass;
		logic        [15:0] oth_inv_mass;
	} in_item_t;

	typedef struct packed {
		logic               overlap;
		logic signed [31:0] cur_shift_x;
		logic signed [31:0] cur_shift_y;
		logic signed [31:0] oth_shift_x;
		logic signed [31:0] oth_shift_y;
		logic               other_moved;
	} out_item_t;

	typedef struct packed {
		logic ov;
		logic on_y;
		logic neg;
		logic moved;
	} side_t;

	typedef struct packed {
		logic [NW-1:0] num_c;
		logic [NW-1:0] num_o;
		logic [DW-1:0] den;
		side_t         side;
	} div_req_t;

	typedef struct packed {
		logic [DW-1:0] r;
		logic [QW-1:0] n;
	} div_lane_t;

	typedef struct packed {
		div_lane_t     c;
		div_lane_t     o;
		logic [DW-1:0] d;
		side_t         side;
	} div_stage_t;

	// one restoring step: shift a dividend bit in, keep the quotient bit
	function automatic div_lane_t div_step(div_lane_t a, logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] s;
		logic        ge;
		div_lane_t   res;
		t = {a.r, a.n[QW-1]};
		s = t - {1'b0, d};
		ge = (t >= {1'b0, d});
		res.r = ge ? s[DW-1:0] : t[DW-1:0];
		res.n = {a.n[QW-2:0], ge};
		return res;
	endfunction

	function automatic div_lane_t div_load(logic [NW-1:0] num);
		div_lane_t res;
		res.r = {1'b0, num[NW-1:QW]};
		res.n = num[QW-1:0];
		return res;
	endfunction

	function automatic logic [31:0] sat_signed(logic [QW-1:0] mag, logic neg);
		logic [31:0] res;
		if (neg) begin
			if (mag >= QW'(33'h080000000)) res = 32'h80000000;
			else res = 32'd0 - mag[31:0];
		end else begin
			if (mag > QW'(33'h07FFFFFFF)) res = 32'h7FFFFFFF;
			else res = mag[31:0];
		end
		return res;
	endfunction

endpackage

// File: src/aabb_collision_resolve.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  in_data  (aabbcr_pkg::in_item_t)
// out      output     out_valid/out_ready  out_data (aabbcr_pkg::out_item_t)
// cfg      input      APB psel/penable     step_reciprocal at byte address 0
//
// One transaction enters per cycle unless the output stalls. It passes five front
// stages (overlap, depths, split multiply, push, mass split), 41 restoring divider
// stages (one quotient bit each, both shares in parallel) and the output register.
// Reset clears every valid bit and loads step_reciprocal with 60.0.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
module aabb_collision_resolve (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  aabbcr_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output aabbcr_pkg::out_item_t out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [23:0] step_recip_q;
	logic        en;

	// advance whenever the output register is free or being drained
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_recip_q <= aabbcr_pkg::STEP_RECIP_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == aabbcr_pkg::REG_STEP_RECIP)) begin
			step_recip_q <= pwdata[23:0];
		end
	end

	// index beyond the list reads as zero
	assign prdata = (paddr[2] == aabbcr_pkg::REG_STEP_RECIP) ? {8'd0, step_recip_q} : 32'd0;

	logic                   req_vld, res_vld;
	aabbcr_pkg::div_req_t   req;
	aabbcr_pkg::div_stage_t res;

	aabbcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (in_valid),
		.in_item    (in_data),
		.step_recip (step_recip_q),
		.req_vld    (req_vld),
		.req        (req)
	);

	aabbcr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.req_vld (req_vld),
		.req     (req),
		.res_vld (res_vld),
		.res     (res)
	);

	// saturate, place on the chosen axis; the second box moves against the push
	logic [31:0] cur_sat, oth_sat;
	assign cur_sat = aabbcr_pkg::sat_signed(res.c.n, res.side.neg);
	assign oth_sat = aabbcr_pkg::sat_signed(res.o.n, !res.side.neg);

	aabbcr_pkg::out_item_t out_next;

	always_comb begin
		out_next = '0;
		if (res.side.ov) begin
			out_next.overlap = 1'b1;
			out_next.other_moved = res.side.moved;
			if (res.side.on_y) begin
				out_next.cur_shift_y = cur_sat;
				out_next.oth_shift_y = oth_sat;
			end else begin
				out_next.cur_shift_x = cur_sat;
				out_next.oth_shift_x = oth_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= res_vld;
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= out_next;
	end

endmodule

// File: src/aabbcr_front.sv
module aabbcr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  aabbcr_pkg::in_item_t in_item,
	input  logic [23:0]          step_recip,
	output logic                 req_vld,
	output aabbcr_pkg::div_req_t req
);

	localparam int unsigned GW = aabbcr_pkg::GW;
	localparam int unsigned PW = aabbcr_pkg::PW;
	localparam int unsigned NW = aabbcr_pkg::NW;
	localparam int unsigned DW = aabbcr_pkg::DW;

	// stage 1: overlap test, doubled centre gaps, scale factor
	logic signed [33:0] cx, cy, ox, oy, cw, ch, ow, oh;
	logic               ovl;
	logic signed [10:0] bm;
	logic signed [GW-1:0] fac;
	logic signed [GW-1:0] dx2, dy2;

	assign cx = 34'(in_item.cur_x_pos);
	assign cy = 34'(in_item.cur_y_pos);
	assign ox = 34'(in_item.oth_x_pos);
	assign oy = 34'(in_item.oth_y_pos);
	assign cw = $signed({3'b000, in_item.cur_width});
	assign ch = $signed({3'b000, in_item.cur_height});
	assign ow = $signed({3'b000, in_item.oth_width});
	assign oh = $signed({3'b000, in_item.oth_height});
	assign ovl = (cx < ox + ow) && (cx + cw > ox) && (cy < oy + oh) && (cy + ch > oy);
	assign dx2 = 2 * GW'(cx) + GW'(cw) - 2 * GW'(ox) - GW'(ow);
	assign dy2 = 2 * GW'(cy) + GW'(ch) - 2 * GW'(oy) - GW'(oh);
	assign bm = $signed({2'b00, in_item.cur_bounce} + {2'b00, in_item.oth_bounce}) - 11'sd512;
	assign fac = GW'(bm) * GW'($signed({1'b0, step_recip})) + (GW'(1) <<< 25);

	logic                 vld_s1, ov_s1;
	logic signed [GW-1:0] dx2_s1, dy2_s1, fac_s1;
	logic [31:0]          sw_s1, sh_s1;
	logic [15:0]          ic_s1, io_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ov_s1 <= ovl;
			dx2_s1 <= dx2;
			dy2_s1 <= dy2;
			fac_s1 <= fac;
			sw_s1 <= {1'b0, in_item.cur_width} + {1'b0, in_item.oth_width};
			sh_s1 <= {1'b0, in_item.cur_height} + {1'b0, in_item.oth_height};
			ic_s1 <= in_item.cur_inv_mass;
			io_s1 <= in_item.oth_inv_mass;
		end
	end

	// stage 2: depths, axis choice, direction, factor magnitude
	logic [GW-1:0]        adx, ady;
	logic signed [GW:0]   depx2, depy2;
	logic                 on_y, gneg;

	assign adx = dx2_s1[GW-1] ? GW'(-dx2_s1) : GW'(dx2_s1);
	assign ady = dy2_s1[GW-1] ? GW'(-dy2_s1) : GW'(dy2_s1);
	assign depx2 = $signed({5'b00000, sw_s1}) - $signed({1'b0, adx});
	assign depy2 = $signed({5'b00000, sh_s1}) - $signed({1'b0, ady});
	assign on_y = depx2 > depy2;
	assign gneg = on_y ? !(dy2_s1 > 0) : !(dx2_s1 > 0);

	logic        vld_s2, ov_s2, on_y_s2, neg_s2;
	logic [31:0] dep_s2;
	logic [33:0] fm_s2;
	logic [15:0] ic_s2, io_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ov_s2 <= ov_s1;
			on_y_s2 <= on_y;
			dep_s2 <= on_y ? depy2[31:0] : depx2[31:0];
			neg_s2 <= gneg ^ fac_s1[GW-1];
			fm_s2 <= fac_s1[GW-1] ? 34'(-fac_s1) : fac_s1[33:0];
			ic_s2 <= ic_s1;
			io_s2 <= io_s1;
		end
	end

	// stage 3: partial products of depth times factor
	logic        vld_s3, ov_s3, on_y_s3, neg_s3;
	logic [48:0] ph_s3, pl_s3;
	logic [15:0] ic_s3, io_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ov_s3 <= ov_s2;
			on_y_s3 <= on_y_s2;
			neg_s3 <= neg_s2;
			ph_s3 <= {17'd0, dep_s2} * {32'd0, fm_s2[33:17]};
			pl_s3 <= {17'd0, dep_s2} * {32'd0, fm_s2[16:0]};
			ic_s3 <= ic_s2;
			io_s3 <= io_s2;
		end
	end

	// stage 4: combine partial products, drop 26 fraction bits
	logic [49:0] low_sum;
	assign low_sum = {24'd0, ph_s3[8:0], 17'd0} + {1'b0, pl_s3};

	logic          vld_s4, ov_s4, on_y_s4, neg_s4;
	logic [PW-1:0] push_s4;
	logic [15:0]   ic_s4, io_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ov_s4 <= ov_s3;
			on_y_s4 <= on_y_s3;
			neg_s4 <= neg_s3;
			push_s4 <= PW'(ph_s3[48:9]) + PW'(low_sum[49:26]);
			ic_s4 <= ic_s3;
			io_s4 <= io_s3;
		end
	end

	// stage 5: mass split setup; an immovable box hands the whole push over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) req_vld <= 1'b0;
		else if (en) req_vld <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req.side.ov <= ov_s4;
			req.side.on_y <= on_y_s4;
			req.side.neg <= neg_s4;
			req.side.moved <= (io_s4 != 16'd0);
			if (io_s4 == 16'd0) begin
				req.num_c <= NW'(push_s4);
				req.num_o <= '0;
				req.den <= DW'(1);
			end else if (ic_s4 == 16'd0) begin
				req.num_c <= '0;
				req.num_o <= NW'(push_s4);
				req.den <= DW'(1);
			end else begin
				req.num_c <= NW'(push_s4) * NW'(ic_s4);
				req.num_o <= NW'(push_s4) * NW'(io_s4);
				req.den <= {1'b0, ic_s4} + {1'b0, io_s4};
			end
		end
	end

endmodule

// File: src/aabbcr_div.sv
module aabbcr_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   req_vld,
	input  aabbcr_pkg::div_req_t   req,
	output logic                   res_vld,
	output aabbcr_pkg::div_stage_t res
);

	localparam int unsigned QW = aabbcr_pkg::QW;

	aabbcr_pkg::div_stage_t stg [QW];
	logic                   vld [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		aabbcr_pkg::div_stage_t src;
		logic                   src_vld;

		if (k == 0) begin : g_load
			assign src.c = aabbcr_pkg::div_load(req.num_c);
			assign src.o = aabbcr_pkg::div_load(req.num_o);
			assign src.d = req.den;
			assign src.side = req.side;
			assign src_vld = req_vld;
		end else begin : g_chain
			assign src = stg[k-1];
			assign src_vld = vld[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld[k] <= 1'b0;
			else if (en) vld[k] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg[k].c <= aabbcr_pkg::div_step(src.c, src.d);
				stg[k].o <= aabbcr_pkg::div_step(src.o, src.d);
				stg[k].d <= src.d;
				stg[k].side <= src.side;
			end
		end
	end

	assign res_vld = vld[QW-1];
	assign res = stg[QW-1];

endmodule

// File: src/aabbcr_checker.sv
module aabbcr_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input aabbcr_pkg::out_item_t out_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a stalled output stalls the input side too
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted during output stall");

	a_noov: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.overlap |-> out_data.cur_shift_x == 0 &&
		out_data.cur_shift_y == 0 && out_data.oth_shift_x == 0 &&
		out_data.oth_shift_y == 0 && !out_data.other_moved)
		else $error("non-overlap result not zero");

	a_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.other_moved |->
		out_data.oth_shift_x == 0 && out_data.oth_shift_y == 0)
		else $error("immovable box shifted");

	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.cur_shift_x == 0 || out_data.cur_shift_y == 0))
		else $error("push on both axes");

endmodule

bind aabb_collision_resolve aabbcr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
